### design/gmh_pkg.sv
// Shared widths, types and register indexes for the genotype MAF/HWE filter.
`default_nettype none
package gmh_pkg;
  localparam int unsigned MAX_SAMPLES = 65536;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned CNT_W       = 17;
  localparam int unsigned FREQ_W      = 17;
  localparam int unsigned MINOR_W     = 16;
  localparam int unsigned CHISQ_W     = 33;
  localparam int unsigned THR_W       = 16;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 33;
  localparam int unsigned MC_W        = 66;
  localparam int unsigned MP_W        = 35;
  localparam int unsigned PROD_W      = MC_W + MP_W;
  localparam int unsigned DVD_W       = 98;
  localparam int unsigned DVS_W       = 66;
  localparam int unsigned Q_W         = 35;
  localparam int unsigned IN_DATA_W   = 8;
  localparam int unsigned OUT_DATA_W  = 104;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_MAF   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHISQ_MAX = 8'd1;

  localparam logic [1:0] GENO_HOM_ZERO = 2'd0;
  localparam logic [1:0] GENO_HET      = 2'd1;
  localparam logic [1:0] GENO_HOM_TWO  = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0] hom_zero;
    logic [CNT_W-1:0] het;
    logic [CNT_W-1:0] hom_two;
    logic [CNT_W-1:0] called;
  } counts_t;
endpackage
`default_nettype wire

### design/gmh_count.sv
// Per-variant genotype class counters with a snapshot taken on the last sample.
`default_nettype none
module gmh_count (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  accept,
  input  wire [1:0]            genotype,
  input  wire                  missing,
  input  wire                  last,
  output gmh_pkg::counts_t     snap,
  output logic                 snap_valid
);
  gmh_pkg::counts_t cnt;
  gmh_pkg::counts_t cnt_next;
  logic             called;

  always_comb begin
    called   = !missing && (genotype != 2'd3) &&
               (cnt.called < gmh_pkg::CNT_W'(gmh_pkg::MAX_SAMPLES));
    cnt_next = cnt;
    if (called) begin
      cnt_next.called = cnt.called + 1'b1;
      case (genotype)
        gmh_pkg::GENO_HOM_ZERO: cnt_next.hom_zero = cnt.hom_zero + 1'b1;
        gmh_pkg::GENO_HET:      cnt_next.het      = cnt.het + 1'b1;
        gmh_pkg::GENO_HOM_TWO:  cnt_next.hom_two  = cnt.hom_two + 1'b1;
        default:                cnt_next = cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      snap_valid <= 1'b0;
    end else begin
      snap_valid <= accept && last;
      if (accept) begin
        if (last) begin
          cnt <= '0;
        end else begin
          cnt <= cnt_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      snap <= cnt_next;
    end
  end
endmodule
`default_nettype wire

### design/gmh_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`default_nettype none
module gmh_mul (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire [gmh_pkg::MC_W-1:0]      mcand,
  input  wire [gmh_pkg::MP_W-1:0]      mplier,
  output logic                         done,
  output logic [gmh_pkg::PROD_W-1:0]   product
);
  logic [gmh_pkg::MC_W-1:0] mc;
  logic [gmh_pkg::MC_W-1:0] hi;
  logic [gmh_pkg::MP_W-1:0] lo;
  logic [5:0]               cnt;
  logic                     run;
  logic [gmh_pkg::MC_W:0]   sum;

  assign sum     = {1'b0, hi} + {1'b0, (lo[0] ? mc : '0)};
  assign product = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == 6'(gmh_pkg::MP_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc <= mcand;
      hi <= '0;
      lo <= mplier;
    end else if (run) begin
      hi <= sum[gmh_pkg::MC_W:1];
      lo <= {sum[0], lo[gmh_pkg::MP_W-1:1]};
    end
  end
endmodule
`default_nettype wire

### design/gmh_div.sv
// Bit-serial restoring divider, one dividend bit per cycle, with quotient overflow flag.
`default_nettype none
module gmh_div (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         start,
  input  wire [gmh_pkg::DVD_W-1:0]    dividend,
  input  wire [gmh_pkg::DVS_W-1:0]    divisor,
  output logic                        done,
  output logic [gmh_pkg::Q_W-1:0]     quotient,
  output logic                        ovf
);
  logic [gmh_pkg::DVS_W-1:0] rem;
  logic [gmh_pkg::DVD_W-1:0] dvd;
  logic [gmh_pkg::DVS_W-1:0] dv;
  logic [6:0]                cnt;
  logic                      run;
  logic [gmh_pkg::DVS_W:0]   trial;
  logic [gmh_pkg::DVS_W:0]   diff;
  logic                      ge;

  assign trial = {rem, dvd[gmh_pkg::DVD_W-1]};
  assign ge    = trial >= {1'b0, dv};
  assign diff  = trial - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == 7'(gmh_pkg::DVD_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvd      <= dividend;
      dv       <= divisor;
      quotient <= '0;
      ovf      <= 1'b0;
    end else if (run) begin
      rem      <= ge ? diff[gmh_pkg::DVS_W-1:0] : trial[gmh_pkg::DVS_W-1:0];
      dvd      <= {dvd[gmh_pkg::DVD_W-2:0], 1'b0};
      quotient <= {quotient[gmh_pkg::Q_W-2:0], ge};
      ovf      <= ovf | quotient[gmh_pkg::Q_W-1];
    end
  end
endmodule
`default_nettype wire

### design/gmh_stats.sv
// Sequencer that runs the frequency and chi-square arithmetic and holds the result.
`default_nettype none
module gmh_stats (
  input  wire                                clk,
  input  wire                                rst,
  input  gmh_pkg::counts_t                   snap,
  input  wire                                snap_valid,
  input  wire [gmh_pkg::THR_W-1:0]           min_maf,
  input  wire [gmh_pkg::CHISQ_W-1:0]         chisq_max,
  output logic                               idle,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [gmh_pkg::OUT_DATA_W-1:0]     m_tdata
);
  typedef enum logic [1:0] {S_IDLE, S_LAUNCH, S_WAIT, S_OUT} state_t;
  typedef enum logic [2:0] {
    OP_AC, OP_BB, OP_XY, OP_DD, OP_DDN, OP_DEN, OP_CODED, OP_CHISQ
  } op_t;

  state_t state;
  op_t    op;

  logic [gmh_pkg::CNT_W-1:0] a, b, c, n;
  logic [gmh_pkg::CNT_W:0]   x, y, b2c;
  logic [33:0] ac, bb, d;
  logic [35:0] xy;
  logic [65:0] dd, den;
  logic [81:0] ddn;
  logic [gmh_pkg::FREQ_W-1:0] coded;

  logic [gmh_pkg::MC_W-1:0]   mcand;
  logic [gmh_pkg::MP_W-1:0]   mplier;
  logic [gmh_pkg::PROD_W-1:0] product;
  logic                       mul_done, mul_start;
  logic [gmh_pkg::DVD_W-1:0]  dividend;
  logic [gmh_pkg::DVS_W-1:0]  divisor;
  logic [gmh_pkg::Q_W-1:0]    quotient;
  logic                       div_done, div_start, div_ovf, unit_done;
  logic [35:0]                p4;
  logic                       load;

  logic                        degen, n_zero, out_keep, out_degen;
  logic [gmh_pkg::FREQ_W-1:0]  f_coded, f_other;
  logic [gmh_pkg::MINOR_W-1:0] f_minor;
  logic [gmh_pkg::CHISQ_W-1:0] chisq_sat, f_chisq;

  assign x   = {a, 1'b0} + {1'b0, b};
  assign y   = {c, 1'b0} + {1'b0, b};
  assign b2c = {c, 1'b0} + {1'b0, b};
  assign p4  = {ac, 2'b00};

  always_comb begin
    case (op)
      OP_AC:   begin mcand = gmh_pkg::MC_W'(a);   mplier = gmh_pkg::MP_W'(c);  end
      OP_BB:   begin mcand = gmh_pkg::MC_W'(b);   mplier = gmh_pkg::MP_W'(b);  end
      OP_XY:   begin mcand = gmh_pkg::MC_W'(x);   mplier = gmh_pkg::MP_W'(y);  end
      OP_DD:   begin mcand = gmh_pkg::MC_W'(d);   mplier = gmh_pkg::MP_W'(d);  end
      OP_DDN:  begin mcand = dd;                  mplier = gmh_pkg::MP_W'(n);  end
      OP_DEN:  begin mcand = gmh_pkg::MC_W'(xy);  mplier = gmh_pkg::MP_W'(xy); end
      default: begin mcand = '0;                  mplier = '0;                 end
    endcase
    if (op == OP_CODED) begin
      dividend = (gmh_pkg::DVD_W'(b2c) << gmh_pkg::FRAC_BITS) + gmh_pkg::DVD_W'(n);
      divisor  = gmh_pkg::DVS_W'({n, 1'b0});
    end else begin
      dividend = (gmh_pkg::DVD_W'(ddn) << (gmh_pkg::FRAC_BITS + 1)) +
                 gmh_pkg::DVD_W'(den);
      divisor  = {den[64:0], 1'b0};
    end
  end

  assign mul_start = (state == S_LAUNCH) && (op != OP_CODED) && (op != OP_CHISQ);
  assign div_start = (state == S_LAUNCH) && ((op == OP_CODED) || (op == OP_CHISQ));
  assign unit_done = mul_done || div_done;
  assign idle      = (state == S_IDLE);
  assign load      = (state == S_OUT) && (!m_tvalid || m_tready);

  gmh_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mcand),
    .mplier  (mplier),
    .done    (mul_done),
    .product (product)
  );

  gmh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient),
    .ovf      (div_ovf)
  );

  always_comb begin
    n_zero    = (n == '0);
    degen     = n_zero || (x == '0) || (y == '0);
    chisq_sat = (div_ovf || (quotient[gmh_pkg::Q_W-1:gmh_pkg::CHISQ_W] != '0)) ?
                '1 : quotient[gmh_pkg::CHISQ_W-1:0];
    f_coded   = n_zero ? '0 : coded;
    f_other   = n_zero ? '0 : (gmh_pkg::FREQ_W'(1 << gmh_pkg::FRAC_BITS) - coded);
    f_minor   = (f_coded < f_other) ? f_coded[gmh_pkg::MINOR_W-1:0] :
                                      f_other[gmh_pkg::MINOR_W-1:0];
    f_chisq   = degen ? '0 : chisq_sat;
    out_degen = degen;
    out_keep  = !degen && (f_minor >= min_maf) && (f_chisq <= chisq_max);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      op       <= OP_AC;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (snap_valid) begin
            op    <= OP_AC;
            state <= S_LAUNCH;
          end
        end
        S_LAUNCH: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (unit_done) begin
            if (op == OP_CHISQ) begin
              state <= S_OUT;
            end else begin
              op    <= op.next();
              state <= S_LAUNCH;
            end
          end
        end
        S_OUT: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (idle && snap_valid) begin
      a <= snap.hom_zero;
      b <= snap.het;
      c <= snap.hom_two;
      n <= snap.called;
    end
    if (state == S_WAIT && unit_done) begin
      case (op)
        OP_AC:    ac    <= product[33:0];
        OP_BB:    bb    <= product[33:0];
        OP_XY: begin
          xy <= product[35:0];
          d  <= (p4[33:0] >= bb) ? (p4[33:0] - bb) : (bb - p4[33:0]);
        end
        OP_DD:    dd    <= product[65:0];
        OP_DDN:   ddn   <= product[81:0];
        OP_DEN:   den   <= product[65:0];
        OP_CODED: coded <= quotient[gmh_pkg::FREQ_W-1:0];
        default:  ac    <= ac;
      endcase
    end
    if (load) begin
      m_tdata <= {2'b00, out_degen, out_keep, f_chisq, f_minor, f_other, f_coded, n};
    end
  end

`ifndef NO_ASSERTIONS
  a_keep_not_degen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[100] && m_tdata[101]))
    else $error("keep set on a degenerate result");
  a_minor_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[66:51] <= 16'd32768))
    else $error("minor frequency above one half");
  a_freq_sum: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[16:0] != '0) |->
      (18'(m_tdata[33:17]) + 18'(m_tdata[50:34]) == 18'(1 << gmh_pkg::FRAC_BITS)))
    else $error("coded and other frequencies do not sum to one");
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result changed while waiting");
`endif
endmodule
`default_nettype wire

### design/genotype_maf_hwe_filter.sv
// Top level: counts genotype classes per variant and reports MAF and HWE filter results.
// Samples are accepted back to back while the sequencer is idle and no snapshot is pending.
// After the last sample the result is built from six serial products and two serial
// quotients, then registered for output; no samples are taken meanwhile.
// A finished result waits in the output register while the next variant streams in.
// Synchronous reset clears counts, sequencer and output valid; threshold 0, limit 2^32.
`default_nettype none
module genotype_maf_hwe_filter (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire [gmh_pkg::IN_DATA_W-1:0]       s_tdata,   // genotype[1:0], missing[2]
  input  wire                                s_tlast,
  output logic                               m_tvalid,
  input  wire                                m_tready,
  // called_count, coded_freq, other_freq, minor_freq, chisq, keep, degenerate
  output logic [gmh_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [gmh_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [gmh_pkg::CFG_DATA_W-1:0]      cfg_data
);
  logic [gmh_pkg::THR_W-1:0]   min_maf;
  logic [gmh_pkg::CHISQ_W-1:0] chisq_max;
  gmh_pkg::counts_t            snap;
  logic                        snap_valid;
  logic                        idle;
  logic                        accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = idle && !snap_valid;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_maf   <= '0;
      chisq_max <= gmh_pkg::CHISQ_W'(64'h1_0000_0000);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gmh_pkg::REG_MIN_MAF:   min_maf   <= cfg_data[gmh_pkg::THR_W-1:0];
        gmh_pkg::REG_CHISQ_MAX: chisq_max <= cfg_data[gmh_pkg::CHISQ_W-1:0];
        default:                min_maf   <= min_maf;
      endcase
    end
  end

  gmh_count u_count (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .genotype   (s_tdata[1:0]),
    .missing    (s_tdata[2]),
    .last       (s_tlast),
    .snap       (snap),
    .snap_valid (snap_valid)
  );

  gmh_stats u_stats (
    .clk        (clk),
    .rst        (rst),
    .snap       (snap),
    .snap_valid (snap_valid),
    .min_maf    (min_maf),
    .chisq_max  (chisq_max),
    .idle       (idle),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );
endmodule
`default_nettype wire
